// ===== design/bf5_pkg.sv =====
// Shared constants and types for the 5x5 box filter stream core.
`timescale 1ns / 1ps

package bf5_pkg;

	localparam int BF5_MAX_WIDTH = 1024;
	localparam int KERNEL_SIZE   = 5;
	localparam int CENTER_OFS    = KERNEL_SIZE / 2;
	localparam int DIM_MIN       = 5;
	localparam int DIM_MAX       = 1024;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;

	localparam int PIX_W     = 8;
	localparam int LS_WORD_W = (KERNEL_SIZE - 1) * PIX_W;
	localparam int COLSUM_W  = 11;
	localparam int WSUM_W    = 13;

	// floor(x / 25) == (x * 5243) >> 17 for every x below 43690.
	localparam int DIV25_MUL   = 5243;
	localparam int DIV25_SHIFT = 17;
	localparam int PROD_W      = 2 * WSUM_W;

	localparam int OUT_DEPTH   = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_PAD_W   = OUT_TDATA_W - PIX_W - 20;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic       has_res;
		logic [9:0] row;
		logic [9:0] col;
		logic       last;
	} bf5_tag_t;

	typedef struct packed {
		bf5_tag_t         tag;
		logic [PIX_W-1:0] smoothed;
	} bf5_result_t;

endpackage

// ===== design/bf5_line_store.sv =====
// Line store memory: four previous lines packed into one word per column.
`timescale 1ns / 1ps

module bf5_line_store import bf5_pkg::*; #(
	parameter int MAX_WIDTH = BF5_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [LS_WORD_W-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [LS_WORD_W-1:0] wr_data
);

	logic [LS_WORD_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/bf5_window_sum.sv =====
// Column sums, running 5x5 window sum and the divide by 25.
`timescale 1ns / 1ps

module bf5_window_sum import bf5_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  bf5_tag_t             in_tag,
	input  logic [LS_WORD_W-1:0] in_lines,
	input  logic [PIX_W-1:0]     in_pixel,
	output logic [2:0]           stage_valid,
	output logic                 out_valid,
	output bf5_result_t          out_result
);

	logic [COLSUM_W-1:0] colsum;
	logic [COLSUM_W-1:0] colsum_s2;
	logic [COLSUM_W-1:0] cs_q [KERNEL_SIZE-1];
	logic [WSUM_W-1:0]   wsum;
	logic [WSUM_W-1:0]   sum_s3;
	logic [PROD_W-1:0]   prod;
	logic                valid_s2, valid_s3, valid_s4;
	bf5_tag_t            tag_s2, tag_s3, tag_s4;
	logic [PIX_W-1:0]    smoothed_s4;

	always_comb begin
		colsum = COLSUM_W'(in_pixel);
		for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
			colsum = colsum + COLSUM_W'(in_lines[i*PIX_W +: PIX_W]);
		end
	end

	// The window is held as its five column sums; the newest column is colsum_s2.
	always_comb begin
		wsum = WSUM_W'(colsum_s2);
		for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
			wsum = wsum + WSUM_W'(cs_q[i]);
		end
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(DIV25_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
				cs_q[i] <= '0;
			end
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			if (valid_s2) begin
				for (int i = 0; i < KERNEL_SIZE - 2; i++) begin
					cs_q[i] <= cs_q[i+1];
				end
				cs_q[KERNEL_SIZE-2] <= colsum_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		colsum_s2   <= colsum;
		tag_s2      <= in_tag;
		sum_s3      <= wsum;
		tag_s3      <= tag_s2;
		smoothed_s4 <= prod[DIV25_SHIFT +: PIX_W];
		tag_s4      <= tag_s3;
	end

	assign stage_valid         = {valid_s4, valid_s3, valid_s2};
	assign out_valid           = valid_s4;
	assign out_result.tag      = tag_s4;
	assign out_result.smoothed = smoothed_s4;

endmodule

// ===== design/bf5_out_fifo.sv =====
// Small output queue that decouples the filter pipeline from the output stall.
`timescale 1ns / 1ps

module bf5_out_fifo import bf5_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  bf5_result_t push_data,
	output logic        out_valid,
	input  logic        out_ready,
	output bf5_result_t out_data,
	output logic [CW-1:0] count
);

	bf5_result_t   store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = store_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/box_filter_5x5_stream_core.sv =====
// Top level of the 5x5 box filter: counters, configuration, line store control.
`timescale 1ns / 1ps

// Takes one pixel per clock in raster order and, for each pixel that completes a full 5x5
// window, delivers floor(sum/25) tagged with the centre's row and column; border pixels give
// no word. Throughput is one pixel per clock while s_axis_tready is high, set by the line
// store, read once per pixel and written back in the next cycle at the same column. Pixels
// pass s1, stages s2 to s4 and an eight-word output queue, which lets input continue while
// results wait; s_axis_tready falls only when queued words and pixels in flight fill it.
// Width and height are clamped to 5..1024 (width also to MAX_WIDTH) and should be written
// between frames. The line store needs no clearing pass after reset.
module box_filter_5x5_stream_core import bf5_pkg::*; #(
	parameter int MAX_WIDTH = BF5_MAX_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] smoothed, [17:8] center_row,
	                                               // [27:18] center_col, [31:28] zero
	output logic                   m_axis_tlast,   // frame_last
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [10:0]            cfg_data
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WMAX = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
	localparam int WRST = (WIDTH_RESET < WMAX) ? WIDTH_RESET : WMAX;
	localparam int CW   = $clog2(OUT_DEPTH + 1);

	function automatic logic [10:0] clamp_dim(logic [10:0] v, logic [10:0] hi);
		logic [10:0] r;
		r = v;
		if (v < 11'(DIM_MIN)) begin
			r = 11'(DIM_MIN);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	logic [10:0]          width_q, height_q;
	logic [9:0]           col_q, row_q;
	logic [10:0]          col_inc, row_inc;
	logic                 col_wrap, row_wrap;
	logic                 in_accept;
	logic [31:0]          col_ext;
	logic [AW-1:0]        rd_addr;
	bf5_tag_t             tag_in;

	logic                 valid_s1;
	logic [PIX_W-1:0]     px_s1;
	logic [AW-1:0]        addr_s1;
	bf5_tag_t             tag_s1;
	logic [LS_WORD_W-1:0] lines;

	logic [2:0]           stage_valid;
	logic                 res_valid;
	bf5_result_t          res;
	logic                 push;
	bf5_result_t          out_res;
	logic [CW-1:0]        fifo_count;
	logic [2:0]           inflight;

	// Configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'(WRST);
			height_q <= 11'(HEIGHT_RESET);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= clamp_dim(cfg_data, 11'(WMAX));
				REG_IMAGE_HEIGHT: height_q <= clamp_dim(cfg_data, 11'(DIM_MAX));
				default: ;
			endcase
		end
	end

	// Position of the incoming pixel
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign col_inc   = {1'b0, col_q} + 11'd1;
	assign row_inc   = {1'b0, row_q} + 11'd1;
	assign col_wrap  = (col_inc >= width_q);
	assign row_wrap  = (row_inc >= height_q);

	assign col_ext = 32'(col_q);
	assign rd_addr = (col_ext < 32'(MAX_WIDTH)) ? col_ext[AW-1:0] : AW'(MAX_WIDTH - 1);

	assign tag_in.has_res = (col_q >= 10'(KERNEL_SIZE - 1)) && (row_q >= 10'(KERNEL_SIZE - 1));
	assign tag_in.row     = row_q - 10'(CENTER_OFS);
	assign tag_in.col     = col_q - 10'(CENTER_OFS);
	assign tag_in.last    = col_wrap && row_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
			if (in_accept) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc[9:0];
				end else begin
					col_q <= col_inc[9:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= s_axis_tdata;
		addr_s1 <= rd_addr;
		tag_s1  <= tag_in;
	end

	// Consecutive pixels always address different columns, so the write back of one
	// pixel never meets the read of the next at the same entry.
	bf5_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.rd_en  (in_accept),
		.rd_addr(rd_addr),
		.rd_data(lines),
		.wr_en  (valid_s1),
		.wr_addr(addr_s1),
		.wr_data({px_s1, lines[LS_WORD_W-1:PIX_W]})
	);

	bf5_window_sum u_window_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1),
		.in_tag     (tag_s1),
		.in_lines   (lines),
		.in_pixel   (px_s1),
		.stage_valid(stage_valid),
		.out_valid  (res_valid),
		.out_result (res)
	);

	assign push = res_valid && res.tag.has_res;

	bf5_out_fifo #(
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(res),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_res),
		.count    (fifo_count)
	);

	// Every pixel in flight may still land in the queue, so count them all.
	assign inflight      = 3'(valid_s1) + 3'($countones(stage_valid));
	assign s_axis_tready = (({1'b0, fifo_count} + (CW + 1)'(inflight)) < (CW + 1)'(OUT_DEPTH));

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.tag.col, out_res.tag.row, out_res.smoothed};
	assign m_axis_tlast = out_res.tag.last;

	a_ls_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && valid_s1 |-> rd_addr != addr_s1)
		else $error("line store read meets pending write back at the same column");

	a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> fifo_count < CW'(OUT_DEPTH))
		else $error("result pushed into a full output queue");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, fifo_count} + (CW + 1)'(inflight)) <= (CW + 1)'(OUT_DEPTH))
		else $error("pixels in flight exceed the output queue space");

endmodule

// ===== test/box_filter_checker.sv =====
// Checker for the 5x5 box filter core: mirrors the filter, queues the means due and compares.
`timescale 1ns / 1ps

module box_filter_checker import bf5_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [PIX_W-1:0]       s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [10:0]            cfg_data,
	output int                     failures,
	output int                     pending
);

	typedef struct packed {
		logic [PIX_W-1:0] smoothed;
		logic [9:0]       row;
		logic [9:0]       col;
		logic             last;
	} mean_word_t;

	mean_word_t means_due [$];
	mean_word_t oldest;

	logic [10:0]      width_reg;
	logic [10:0]      height_reg;
	logic [9:0]       row_pos;
	logic [9:0]       col_pos;
	logic [PIX_W-1:0] line_mem [KERNEL_SIZE-1][BF5_MAX_WIDTH];
	logic [PIX_W-1:0] win [KERNEL_SIZE][KERNEL_SIZE];

	function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned hi);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > hi)
			return hi;
		return 32'(v);
	endfunction

	// One pixel through the line stores and the window; a full window queues its mean.
	task automatic filter_pixel(input logic [PIX_W-1:0] px);
		int unsigned      w, h, c, r, ci, total;
		int               i, j;
		logic [PIX_W-1:0] column [KERNEL_SIZE];
		logic             end_of_frame;
		mean_word_t       mean;
		w = clamp_dim(width_reg, (BF5_MAX_WIDTH < DIM_MAX) ? BF5_MAX_WIDTH : DIM_MAX);
		h = clamp_dim(height_reg, DIM_MAX);
		c = 32'(col_pos);
		r = 32'(row_pos);
		ci = (c < BF5_MAX_WIDTH) ? c : BF5_MAX_WIDTH - 1;
		end_of_frame = (c + 1 >= w) && (r + 1 >= h);
		for (i = 0; i < KERNEL_SIZE - 1; i++)
			column[i] = line_mem[i][ci];
		column[KERNEL_SIZE-1] = px;
		for (i = 0; i < KERNEL_SIZE - 2; i++)
			line_mem[i][ci] = line_mem[i+1][ci];
		line_mem[KERNEL_SIZE-2][ci] = px;
		for (i = 0; i < KERNEL_SIZE; i++) begin
			for (j = 0; j < KERNEL_SIZE - 1; j++)
				win[i][j] = win[i][j+1];
			win[i][KERNEL_SIZE-1] = column[i];
		end
		if (r >= KERNEL_SIZE - 1 && c >= KERNEL_SIZE - 1) begin
			total = 0;
			for (i = 0; i < KERNEL_SIZE; i++)
				for (j = 0; j < KERNEL_SIZE; j++)
					total += win[i][j];
			mean.smoothed = PIX_W'(total / (KERNEL_SIZE * KERNEL_SIZE));
			mean.row      = 10'(r - CENTER_OFS);
			mean.col      = 10'(c - CENTER_OFS);
			mean.last     = end_of_frame;
			means_due.push_back(mean);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		col_pos = 10'(c);
		row_pos = 10'(r);
	endtask

	task automatic check_field(input string field, input int unsigned want, got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			means_due.delete();
			failures   = 0;
			pending    = 0;
			width_reg  = 11'(WIDTH_RESET);
			height_reg = 11'(HEIGHT_RESET);
			row_pos    = '0;
			col_pos    = '0;
			for (int i = 0; i < KERNEL_SIZE - 1; i++)
				for (int j = 0; j < BF5_MAX_WIDTH; j++)
					line_mem[i][j] = '0;
			for (int i = 0; i < KERNEL_SIZE; i++)
				for (int j = 0; j < KERNEL_SIZE; j++)
					win[i][j] = '0;
		end else begin
			// A word leaving now was caused by an earlier pixel, so compare first.
			if (m_axis_tvalid && m_axis_tready) begin
				if (means_due.size() == 0) begin
					$error("unexpected output word: tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
					failures++;
				end else begin
					oldest = means_due.pop_front();
					check_field("smoothed", oldest.smoothed, m_axis_tdata[7:0]);
					check_field("center_row", oldest.row, m_axis_tdata[17:8]);
					check_field("center_col", oldest.col, m_axis_tdata[27:18]);
					check_field("tdata padding", 0, m_axis_tdata[31:28]);
					check_field("frame_last", oldest.last, m_axis_tlast);
				end
			end
			// A pixel taken at the same edge as a register write still sees the old size.
			if (s_axis_tvalid && s_axis_tready)
				filter_pixel(s_axis_tdata);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			pending = means_due.size();
		end
	end

endmodule

// ===== test/tb_box_filter_5x5_stream_core.sv =====
// Testbench top for the 5x5 box filter core: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb_box_filter_5x5_stream_core;
	import bf5_pkg::*;

	localparam int SINK_HOLD_CYCLES = 200;

	typedef enum int {
		PIX_UNIFORM,
		PIX_EXTREME,
		PIX_FULL,
		PIX_HIGH,
		PIX_ZERO
	} pixel_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic                   cfg_index;
	logic [10:0]            cfg_data;

	int   failures;
	int   pending;
	int   src_idle_pct;
	int   sink_idle_pct;
	logic sink_hold;

	box_filter_5x5_stream_core dut (.*);

	box_filter_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Output side: random back-pressure, or one long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				sink_hold = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mode_t mode);
		case (mode)
			PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			PIX_FULL:    return 8'hFF;
			PIX_HIGH:    return PIX_W'($urandom_range(240, 255));
			PIX_ZERO:    return 8'h00;
			default:     return PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic push_pixel(input logic [PIX_W-1:0] px);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Let every queued mean come out, then allow for a pixel still in the pipeline.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic run_frames(input logic [10:0] w_reg, h_reg, input int w, h, frames,
	                          input pixel_mode_t mode);
		settle();
		write_reg(REG_IMAGE_WIDTH, w_reg);
		write_reg(REG_IMAGE_HEIGHT, h_reg);
		repeat (frames * w * h) push_pixel(pick_pixel(mode));
	endtask

	// Small frames of random size; a size of five is sometimes written as a value below range.
	task automatic random_frames(input int target);
		int          sent, w, h, frames;
		logic [10:0] w_reg, h_reg;
		pixel_mode_t mode;
		sent = 0;
		while (sent < target) begin
			w = ($urandom_range(3) == 0) ? 5 : $urandom_range(5, 10);
			h = ($urandom_range(3) == 0) ? 5 : $urandom_range(5, 7);
			w_reg = 11'(w);
			h_reg = 11'(h);
			if (w == 5 && $urandom_range(1))
				w_reg = 11'($urandom_range(0, 4));
			if (h == 5 && $urandom_range(1))
				h_reg = 11'($urandom_range(0, 4));
			frames = 1;
			mode = ($urandom_range(7) > 4) ? PIX_UNIFORM : pixel_mode_t'($urandom_range(4));
			run_frames(w_reg, h_reg, w, h, frames, mode);
			sent += frames * w * h;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_IMAGE_WIDTH;
		cfg_data      = '0;
		sink_hold     = 1'b0;
		src_idle_pct  = 22;
		sink_idle_pct = 60;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Smallest frame, every pixel at full scale: one mean of 255 that closes the frame.
		run_frames(11'd5, 11'd5, 5, 5, 1, PIX_FULL);
		// Widest line, written above range, with the height written as zero. Part of the
		// first line shows that it does not wrap early; a narrow width then ends the frame.
		run_frames(11'd2047, 11'd0, 1024, 5, 0, PIX_UNIFORM);
		repeat (30) push_pixel(pick_pixel(PIX_UNIFORM));
		settle();
		write_reg(REG_IMAGE_WIDTH, 11'd5);
		repeat (1 + 4 * 5) push_pixel(pick_pixel(PIX_UNIFORM));
		random_frames(20);

		src_idle_pct  = 60;
		sink_idle_pct = 22;
		// Tall frame at the narrowest width, cut short by a smaller height below the row.
		run_frames(11'd4, 11'd1024, 5, 1024, 0, PIX_EXTREME);
		repeat (8 * 5) push_pixel(pick_pixel(PIX_EXTREME));
		settle();
		write_reg(REG_IMAGE_HEIGHT, 11'd5);
		repeat (5) push_pixel(pick_pixel(PIX_EXTREME));
		random_frames(20);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		// Hold the output off once means are flowing, so the queue fills and input stalls.
		settle();
		write_reg(REG_IMAGE_WIDTH, 11'd10);
		write_reg(REG_IMAGE_HEIGHT, 11'd8);
		repeat (50) push_pixel(pick_pixel(PIX_UNIFORM));
		sink_hold = 1'b1;
		repeat (30) push_pixel(pick_pixel(PIX_UNIFORM));
		random_frames(20);

		// Size changes in the middle of a frame; the counters carry on and wrap at the new limit.
		run_frames(11'd8, 11'd10, 8, 10, 0, PIX_UNIFORM);
		repeat (5 * 8 + 6) push_pixel(pick_pixel(PIX_UNIFORM));
		settle();
		write_reg(REG_IMAGE_WIDTH, 11'd5);
		repeat (18) push_pixel(pick_pixel(PIX_UNIFORM));
		settle();
		write_reg(REG_IMAGE_HEIGHT, 11'd5);
		repeat (26) push_pixel(pick_pixel(PIX_HIGH));
		settle();
		write_reg(REG_IMAGE_WIDTH, 11'd8);
		repeat (30) push_pixel(pick_pixel(PIX_UNIFORM));

		settle();
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
